// ----- design/ccr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the checksum copy realign block
package ccr_pkg;

	// default width of the transfer byte counter
	localparam int CCR_LEN_BITS = 16;

	// configuration port address width and data width
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_SEED = 2'd0;
	localparam logic [1:0] REG_LEN  = 2'd1;
	localparam logic [1:0] REG_SRC  = 2'd2;
	localparam logic [1:0] REG_DST  = 2'd3;

	// reset value of the length register
	localparam logic [15:0] LEN_RESET = 16'd1;

	typedef struct packed {
		logic [31:0] seed;
		logic [15:0] length;
		logic [2:0]  src_off;
		logic [2:0]  dst_off;
	} cfg_t;

	// destination words produced by one source beat
	typedef struct packed {
		logic [63:0] full_data;
		logic [7:0]  full_en;
		logic        has_full;
		logic [63:0] last_data;
		logic [7:0]  last_en;
		logic        fin;
	} res_t;

	// realigned beat handed to the checksum pipeline
	typedef struct packed {
		res_t        res;
		logic [63:0] lane_a;
		logic [63:0] lane_b;
		logic [31:0] seed;
		logic        first;
	} s2_t;

endpackage

// ----- design/ccr_in_if.sv -----
`timescale 1ns / 1ps
// source word channel
interface ccr_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] src_word;

	modport source (output valid, output src_word, input ready);
	modport sink (input valid, input src_word, output ready);
endinterface

// ----- design/ccr_out_if.sv -----
`timescale 1ns / 1ps
// destination word channel
interface ccr_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] dst_word;
	logic [7:0]  byte_enable;
	logic [15:0] folded_sum;
	logic        final_res;

	modport source (output valid, output dst_word, output byte_enable,
		output folded_sum, output final_res, input ready);
	modport sink (input valid, input dst_word, input byte_enable,
		input folded_sum, input final_res, output ready);
endinterface

// ----- design/ccr_regs.sv -----
`timescale 1ns / 1ps
// apb register file for the transfer configuration
module ccr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ccr_pkg::ADDR_W-1:0] paddr,
	input  logic [ccr_pkg::DATA_W-1:0] pwdata,
	output logic [ccr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output ccr_pkg::cfg_t              cfg
);
	import ccr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed    <= '0;
			cfg_q.length  <= LEN_RESET;
			cfg_q.src_off <= '0;
			cfg_q.dst_off <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SEED: cfg_q.seed    <= pwdata;
				REG_LEN:  cfg_q.length  <= pwdata[15:0];
				REG_SRC:  cfg_q.src_off <= pwdata[2:0];
				REG_DST:  cfg_q.dst_off <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SEED: prdata = cfg_q.seed;
			REG_LEN:  prdata = {16'd0, cfg_q.length};
			REG_SRC:  prdata = {29'd0, cfg_q.src_off};
			REG_DST:  prdata = {29'd0, cfg_q.dst_off};
			default:  prdata = '0;
		endcase
	end

endmodule

// ----- design/ccr_align.sv -----
`timescale 1ns / 1ps
// transfer sequencing, input register and byte realignment
module ccr_align #(
	parameter int LEN_BITS = ccr_pkg::CCR_LEN_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ccr_pkg::cfg_t  cfg,
	ccr_in_if.sink         src,
	input  logic           ld3,
	output logic           s2_v,
	output ccr_pkg::s2_t   s2
);
	import ccr_pkg::*;

	// transfer position, advanced at each accepted beat
	logic                first_q;
	logic [LEN_BITS-1:0] left_q;
	logic [2:0]          lpos_q;
	logic [2:0]          dpos_q;

	logic [LEN_BITS-1:0] len_m;
	logic [LEN_BITS-1:0] bl;
	logic [2:0]          b;
	logic [2:0]          lp;
	logic [2:0]          dp;
	logic [3:0]          avail;
	logic [3:0]          k;
	logic                fin;
	logic                acc;
	logic                ld1;
	logic                ld2;

	// input register
	logic        v_s1;
	logic [63:0] word_s1;
	logic [2:0]  b_s1;
	logic [3:0]  k_s1;
	logic [2:0]  lp_s1;
	logic [2:0]  dp_s1;
	logic        first_s1;
	logic        fin_s1;
	logic [31:0] seed_s1;

	// partial checksum lane and partial destination word
	logic [63:0] held_q;
	logic [63:0] dpart_q;
	logic [7:0]  den_q;

	logic [63:0]  sh;
	logic [8:0]   m9;
	logic [7:0]   kmask;
	logic [63:0]  kmask64;
	logic [63:0]  byt;
	logic [63:0]  held_e;
	logic [63:0]  dpart_e;
	logic [7:0]   den_e;
	logic [127:0] cc;
	logic [127:0] cd;
	logic [15:0]  ce;
	logic [3:0]   lsum;
	logic [3:0]   dsum;
	logic [63:0]  held_n;
	logic [63:0]  rem_data;
	logic [7:0]   rem_en;
	logic         con;
	s2_t          s2_n;

	assign len_m = LEN_BITS'(32'(cfg.length));

	always_comb begin
		b     = first_q ? cfg.src_off : 3'd0;
		lp    = first_q ? 3'd0 : lpos_q;
		dp    = first_q ? cfg.dst_off : dpos_q;
		bl    = first_q ? len_m : left_q;
		avail = 4'd8 - {1'b0, b};
		fin   = bl <= LEN_BITS'(avail);
		k     = fin ? bl[3:0] : avail;
	end

	assign ld2       = !s2_v || ld3;
	assign ld1       = !v_s1 || ld2;
	assign src.ready = ld1;
	assign acc       = src.valid && ld1;
	assign con       = v_s1 && ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			left_q  <= '0;
			lpos_q  <= '0;
			dpos_q  <= '0;
		end else if (acc) begin
			first_q <= fin;
			left_q  <= bl - LEN_BITS'(k);
			lpos_q  <= lp + k[2:0];
			dpos_q  <= dp + k[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= src.valid;
			end
			if (ld2) begin
				s2_v <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_s1  <= src.src_word;
			b_s1     <= b;
			k_s1     <= k;
			lp_s1    <= lp;
			dp_s1    <= dp;
			first_s1 <= first_q;
			fin_s1   <= fin;
			seed_s1  <= cfg.seed;
		end
	end

	// take k stream bytes from byte b and drop them at both write positions
	always_comb begin
		sh    = word_s1 >> {b_s1, 3'b000};
		m9    = (9'd1 << k_s1) - 9'd1;
		kmask = m9[7:0];
		for (int i = 0; i < 8; i++) begin
			kmask64[8*i +: 8] = {8{kmask[i]}};
		end
		byt     = sh & kmask64;
		held_e  = first_s1 ? 64'd0 : held_q;
		dpart_e = first_s1 ? 64'd0 : dpart_q;
		den_e   = first_s1 ? 8'd0 : den_q;

		cc   = {64'd0, held_e} | ({64'd0, byt} << {lp_s1, 3'b000});
		cd   = {64'd0, dpart_e} | ({64'd0, byt} << {dp_s1, 3'b000});
		ce   = {8'd0, den_e} | ({8'd0, kmask} << dp_s1);
		lsum = {1'b0, lp_s1} + k_s1;
		dsum = {1'b0, dp_s1} + k_s1;

		held_n   = lsum[3] ? cc[127:64] : cc[63:0];
		rem_data = dsum[3] ? cd[127:64] : cd[63:0];
		rem_en   = dsum[3] ? ce[15:8] : ce[7:0];

		// an incomplete lane adds as zero, which only absorbs the carry
		s2_n.lane_a        = lsum[3] ? cc[63:0] : 64'd0;
		s2_n.lane_b        = fin_s1 ? held_n : 64'd0;
		s2_n.seed          = seed_s1;
		s2_n.first         = first_s1;
		s2_n.res.full_data = cd[63:0];
		s2_n.res.full_en   = ce[7:0];
		s2_n.res.has_full  = dsum[3];
		s2_n.res.last_data = rem_data;
		s2_n.res.last_en   = rem_en;
		s2_n.res.fin       = fin_s1;
	end

	always_ff @(posedge clk) begin
		if (con) begin
			held_q  <= held_n;
			dpart_q <= rem_data;
			den_q   <= rem_en;
			s2      <= s2_n;
		end
	end

endmodule

// ----- design/ccr_csum.sv -----
`timescale 1ns / 1ps
// ones-complement accumulator, final lane add and fold
module ccr_csum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s2_v,
	input  ccr_pkg::s2_t  s2,
	input  logic          ld_out,
	output logic          ld3,
	output logic          s5_v,
	output ccr_pkg::res_t res5,
	output logic [15:0]   folded
);
	import ccr_pkg::*;

	logic [63:0] acc_q;
	logic        carry_q;

	logic [63:0] acc_in;
	logic        cin;
	logic [64:0] sum_a;
	logic [64:0] sum_b;
	logic [63:0] tot;

	logic        v_s3;
	res_t        res_s3;
	logic [63:0] sum_s3;
	logic        c_s3;
	logic [63:0] lb_s3;

	logic        v_s4;
	res_t        res_s4;
	logic [63:0] sum_s4;
	logic        c_s4;

	logic        v_s5;
	res_t        res_s5;
	logic [63:0] tot_s5;

	logic        ld4;
	logic        ld5;

	logic [32:0] f1;
	logic [17:0] f2;
	logic [16:0] f3;
	logic [16:0] f4;

	assign ld5 = !v_s5 || ld_out;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;

	// carry-in never wraps the sum: a set carry leaves the sum below all ones
	always_comb begin
		acc_in = s2.first ? {32'd0, s2.seed} : acc_q;
		cin    = s2.first ? 1'b0 : carry_q;
		sum_a  = {1'b0, acc_in} + {1'b0, s2.lane_a} + {64'd0, cin};
		sum_b  = {1'b0, sum_s3} + {1'b0, lb_s3} + {64'd0, c_s3};
		tot    = sum_s4 + {63'd0, c_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld3) begin
				v_s3 <= s2_v;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
			if (ld5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && ld3) begin
			acc_q   <= sum_a[63:0];
			carry_q <= sum_a[64];
			res_s3  <= s2.res;
			sum_s3  <= sum_a[63:0];
			c_s3    <= sum_a[64];
			lb_s3   <= s2.lane_b;
		end
		if (v_s3 && ld4) begin
			res_s4 <= res_s3;
			sum_s4 <= sum_b[63:0];
			c_s4   <= sum_b[64];
		end
		if (v_s4 && ld5) begin
			res_s5 <= res_s4;
			tot_s5 <= tot;
		end
	end

	// fold 64 bits down to 16 with end-around carries
	always_comb begin
		f1 = {1'b0, tot_s5[31:0]} + {1'b0, tot_s5[63:32]};
		f2 = {2'd0, f1[15:0]} + {1'b0, f1[32:16]};
		f3 = {1'b0, f2[15:0]} + {15'd0, f2[17:16]};
		f4 = {1'b0, f3[15:0]} + {16'd0, f3[16]};
	end

	assign folded = f4[15:0];
	assign s5_v   = v_s5;
	assign res5   = res_s5;

endmodule

// ----- design/ccr_out.sv -----
`timescale 1ns / 1ps
// result register, up to two destination beats per source beat
module ccr_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s5_v,
	input  ccr_pkg::res_t res5,
	input  logic [15:0]   folded,
	output logic          ld_out,
	ccr_out_if.source     dst
);
	import ccr_pkg::*;

	logic        v_q;
	logic        phase_q;
	res_t        res_q;
	logic [15:0] sum_q;
	logic        on_full;
	logic        last_beat;

	// full word goes first, then the final beat if the transfer ends here
	assign on_full   = res_q.has_full && !phase_q;
	assign last_beat = !on_full || !res_q.fin;
	assign ld_out    = !v_q || (dst.ready && last_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= 1'b0;
			phase_q <= 1'b0;
		end else if (ld_out) begin
			v_q     <= s5_v && (res5.has_full || res5.fin);
			phase_q <= 1'b0;
		end else if (dst.ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			res_q <= res5;
			sum_q <= folded;
		end
	end

	always_comb begin
		dst.valid = v_q;
		if (on_full) begin
			dst.dst_word    = res_q.full_data;
			dst.byte_enable = res_q.full_en;
			dst.folded_sum  = 16'd0;
			dst.final_res   = 1'b0;
		end else begin
			dst.dst_word    = res_q.last_data;
			dst.byte_enable = res_q.last_en;
			dst.folded_sum  = sum_q;
			dst.final_res   = 1'b1;
		end
	end

endmodule

// ----- design/checksum_copy_realign.sv -----
`timescale 1ns / 1ps
// top level of the realigning copy engine with ones-complement checksum
//
//  channel  dir  beat contents                                   handshake
//  src      in   src_word                                        valid/ready
//  dst      out  dst_word, byte_enable, folded_sum, final_res    valid/ready
//  apb      in   seed, length, source and destination offsets    psel/penable
//
// one source word per cycle while dst keeps up and no beat needs two dst beats;
// the first result passes the input, realign, accumulate, final add, carry and
// fold/result registers after the source beat is taken
// a source beat that completes a destination word and ends the transfer gives
// two destination beats and holds the result register until both are taken
// a stalled dst fills the pipeline bubbles first, then src ready drops
// reset clears the valid flags, the output phase, the transfer position and the config registers; no memories
module checksum_copy_realign #(
	parameter int LEN_BITS = ccr_pkg::CCR_LEN_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ccr_pkg::ADDR_W-1:0] paddr,
	input  logic [ccr_pkg::DATA_W-1:0] pwdata,
	output logic [ccr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	ccr_in_if.sink                     src,
	ccr_out_if.source                  dst
);
	import ccr_pkg::*;

	cfg_t        cfg;
	logic        s2_v;
	s2_t         s2;
	logic        ld3;
	logic        s5_v;
	res_t        res5;
	logic [15:0] folded;
	logic        ld_out;

	// configuration is sampled by the first source beat of a transfer
	ccr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// byte counting, source extraction and placement at both positions
	ccr_align #(
		.LEN_BITS (LEN_BITS)
	) u_align (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.src    (src),
		.ld3    (ld3),
		.s2_v   (s2_v),
		.s2     (s2)
	);

	// 64-bit sum with deferred carry, one lane add per beat in the loop
	ccr_csum u_csum (
		.clk    (clk),
		.arst_n (arst_n),
		.s2_v   (s2_v),
		.s2     (s2),
		.ld_out (ld_out),
		.ld3    (ld3),
		.s5_v   (s5_v),
		.res5   (res5),
		.folded (folded)
	);

	// result register parts the pipeline from the dst side
	ccr_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.s5_v   (s5_v),
		.res5   (res5),
		.folded (folded),
		.ld_out (ld_out),
		.dst    (dst)
	);

endmodule
